/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mctmf_pkg.sv */
// Shared constants, types and back-end state encoding of the trimmed mean filter.
package mctmf_pkg;

	// Default configuration
	localparam int unsigned WINDOW_DEF   = 30;
	localparam int unsigned CHANNELS_DEF = 8;
	localparam int unsigned TRIM_DEF     = 10;

	// Fixed field widths
	localparam int unsigned SAMPLE_W     = 12;
	localparam int unsigned CHAN_IN_W    = 3;
	localparam int unsigned MAX_CHANNELS = 16;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// Block-end command handed from front to back
	typedef struct packed {
		logic                    bank;
		logic [MAX_CHANNELS-1:0] short_mask;
	} cmd_t;

	// Back reports a bank as fully processed
	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHAN,
		BK_LOAD,
		BK_SUM,
		BK_DIV,
		BK_EMIT
	} back_state_t;

endpackage

/* rtl/core/mctmf_if.sv */
// Handshake interfaces for the sample input and the result output.
interface mctmf_in_if;
	import mctmf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [SAMPLE_W-1:0]  sample;
	logic [CHAN_IN_W-1:0] channel;
	logic                 end_of_block;

	modport source (output valid, sample, channel, end_of_block, input ready);
	modport sink (input valid, sample, channel, end_of_block, output ready);
endinterface

interface mctmf_out_if;
	import mctmf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CHAN_IN_W-1:0] channel_out;
	logic [SAMPLE_W-1:0]  filtered_value;
	logic                 short_window;
	logic                 last_result;

	modport source (output valid, channel_out, filtered_value, short_window, last_result,
		input ready);
	modport sink (input valid, channel_out, filtered_value, short_window, last_result,
		output ready);
endinterface

/* rtl/core/mctmf_queue.sv */
// Two-entry command queue between the front and the back.
module mctmf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mctmf_pkg::cmd_t   push_data,
	output logic              full,
	input  logic              pop,
	output mctmf_pkg::cmd_t   head,
	output logic              empty
);
	import mctmf_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/core/mctmf_front.sv */
// Front end: takes sample words, tracks fill counts, writes the sample store.
module mctmf_front #(
	parameter int unsigned WINDOW   = mctmf_pkg::WINDOW_DEF,
	parameter int unsigned CHANNELS = mctmf_pkg::CHANNELS_DEF,
	localparam int unsigned DEPTH   = 2 * CHANNELS * WINDOW,
	localparam int unsigned ADDR_W  = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mctmf_in_if.sink                      adc,
	input  logic                          q_full,
	output logic                          q_push,
	output mctmf_pkg::cmd_t               q_data,
	input  mctmf_pkg::done_t              done,
	output logic                          wr_en,
	output logic [ADDR_W-1:0]             wr_addr,
	output logic [mctmf_pkg::SAMPLE_W-1:0] wr_data
);
	import mctmf_pkg::*;

	localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned FILL_W = $clog2(WINDOW + 1);

	logic [FILL_W-1:0] fill_q  [CHANNELS];
	logic [FILL_W-1:0] fill_nx [CHANNELS];
	logic              wbank_q;
	logic [1:0]        busy_q;
	logic [1:0]        busy_d;
	logic              accept;
	logic              ch_ok;
	logic              store;
	logic [CH_W-1:0]   ch_idx;

	// Input side: stall while the bank being filled still waits for the back or the queue is full
	assign adc.ready = !busy_q[wbank_q] && !q_full;
	assign accept    = adc.valid && adc.ready;
	assign ch_idx    = CH_W'(adc.channel);
	assign ch_ok     = (int'(adc.channel) < int'(CHANNELS));
	assign store     = accept && ch_ok && (fill_q[ch_idx] < FILL_W'(WINDOW));

	// Store write port
	assign wr_en   = store;
	assign wr_data = adc.sample;
	assign wr_addr = (wbank_q ? ADDR_W'(CHANNELS * WINDOW) : '0)
		+ ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(fill_q[ch_idx]);

	// Fill counts including this word
	always_comb begin
		for (int c = 0; c < int'(CHANNELS); c++) begin
			fill_nx[c] = fill_q[c] + FILL_W'(store && (ch_idx == CH_W'(c)));
		end
	end

	// Block-end command
	assign q_push = accept && adc.end_of_block;
	always_comb begin
		q_data            = '0;
		q_data.bank       = wbank_q;
		for (int c = 0; c < int'(CHANNELS); c++) begin
			q_data.short_mask[c] = (fill_nx[c] < FILL_W'(WINDOW));
		end
	end

	// Bank ownership
	always_comb begin
		busy_d = busy_q;
		if (done.valid) begin
			busy_d[done.bank] = 1'b0;
		end
		if (q_push) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
			for (int c = 0; c < int'(CHANNELS); c++) begin
				fill_q[c] <= '0;
			end
		end else begin
			busy_q <= busy_d;
			if (q_push) begin
				wbank_q <= ~wbank_q;
				for (int c = 0; c < int'(CHANNELS); c++) begin
					fill_q[c] <= '0;
				end
			end else begin
				for (int c = 0; c < int'(CHANNELS); c++) begin
					fill_q[c] <= fill_nx[c];
				end
			end
		end
	end

endmodule

/* rtl/core/mctmf_back.sv */
// Back end: sample store, insertion sorter, trimmed sum, divider and result register.
module mctmf_back #(
	parameter int unsigned WINDOW   = mctmf_pkg::WINDOW_DEF,
	parameter int unsigned CHANNELS = mctmf_pkg::CHANNELS_DEF,
	parameter int unsigned TRIM     = mctmf_pkg::TRIM_DEF,
	localparam int unsigned DEPTH   = 2 * CHANNELS * WINDOW,
	localparam int unsigned ADDR_W  = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  mctmf_pkg::cmd_t                q_head,
	output logic                           q_pop,
	output mctmf_pkg::done_t               done,
	input  logic                           wr_en,
	input  logic [ADDR_W-1:0]              wr_addr,
	input  logic [mctmf_pkg::SAMPLE_W-1:0] wr_data,
	mctmf_out_if.source                    result
);
	import mctmf_pkg::*;

	localparam bit          KEEP_OK  = (2 * TRIM < WINDOW);
	localparam int unsigned KEPT     = KEEP_OK ? (WINDOW - 2 * TRIM) : 1;
	localparam int unsigned SUM_LAST = KEEP_OK ? (WINDOW - TRIM - 1) : 0;
	localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned IDX_W    = $clog2(WINDOW + 1);
	localparam int unsigned SUM_W    = SAMPLE_W + $clog2(WINDOW + 1);
	// reciprocal of the kept count: ceil(2^DIV_S / KEPT), exact for any SUM_W-bit sum
	localparam int unsigned DIV_L    = $clog2(KEPT);
	localparam int unsigned DIV_S    = SUM_W + DIV_L;
	localparam int unsigned PROD_W   = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] DIV_M =
		(SUM_W + 1)'(((64'd1 << DIV_S) + 64'(KEPT) - 64'd1) / 64'(KEPT));

	back_state_t          state_q;
	back_state_t          state_d;
	logic                 bank_q;
	logic [CHANNELS-1:0]  mask_q;
	logic [CH_W-1:0]      chan_q;
	logic [ADDR_W-1:0]    base_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [IDX_W-1:0]     ld_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 rdv_s1;
	logic [SAMPLE_W-1:0]  rd_data_s1;
	logic [SAMPLE_W-1:0]  mem_q [DEPTH];
	logic [SAMPLE_W-1:0]  sorted_q [WINDOW];
	logic [SAMPLE_W-1:0]  ins [WINDOW];
	logic [WINDOW-1:0]    lt;
	logic [SUM_W-1:0]     sum_q;
	logic [PROD_W-1:0]    prod;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 rd_en;
	logic                 ld_last;
	logic                 last_chan;
	logic                 skip_chan;
	logic                 slot_free;
	logic                 emit_fire;
	logic                 out_valid_q;

	assign rd_addr   = base_q + ADDR_W'(rd_idx_q);
	assign ld_last   = (ld_q == IDX_W'(WINDOW - 1));
	assign last_chan = (chan_q == CH_W'(CHANNELS - 1));
	assign skip_chan = mask_q[chan_q] || !KEEP_OK;
	assign slot_free = !out_valid_q || result.ready;

	// Sample store: one write port from the front, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	// Insertion into the sorted row: each cell compares against the new sample
	for (genvar j = 0; j < int'(WINDOW); j++) begin : g_cell
		assign lt[j] = (sorted_q[j] < rd_data_s1);
		if (j == 0) begin : g_first
			assign ins[j] = lt[j] ? sorted_q[j] : rd_data_s1;
		end else begin : g_rest
			assign ins[j] = lt[j] ? sorted_q[j] : (lt[j-1] ? rd_data_s1 : sorted_q[j-1]);
		end
	end

	// Divide by the kept count: multiply by the rounded-up reciprocal, then shift
	assign prod = PROD_W'(sum_q) * PROD_W'(DIV_M);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_CHAN;
				end
			end
			BK_CHAN: begin
				state_d = skip_chan ? BK_EMIT : BK_LOAD;
			end
			BK_LOAD: begin
				if (rdv_s1 && ld_last) begin
					state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				if (idx_q == IDX_W'(SUM_LAST)) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (slot_free) begin
					state_d = last_chan ? BK_IDLE : BK_CHAN;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		emit_fire  = 1'b0;
		case (state_q)
			BK_IDLE: q_pop     = !q_empty;
			BK_LOAD: rd_en     = (rd_idx_q < IDX_W'(WINDOW));
			BK_EMIT: emit_fire = slot_free;
			default: begin
				q_pop = 1'b0;
			end
		endcase
		done.valid = emit_fire && last_chan;
		done.bank  = bank_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_s1  <= rd_en;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					bank_q <= q_head.bank;
					mask_q <= q_head.short_mask[CHANNELS-1:0];
					chan_q <= '0;
					base_q <= q_head.bank ? ADDR_W'(CHANNELS * WINDOW) : '0;
				end
			end
			BK_CHAN: begin
				rd_idx_q <= '0;
				ld_q     <= '0;
				idx_q    <= '0;
				sum_q    <= '0;
				for (int j = 0; j < int'(WINDOW); j++) begin
					sorted_q[j] <= SAMPLE_MAX;
				end
			end
			BK_LOAD: begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (rdv_s1) begin
					ld_q <= ld_q + IDX_W'(1);
					for (int j = 0; j < int'(WINDOW); j++) begin
						sorted_q[j] <= ins[j];
					end
				end
			end
			BK_SUM: begin
				// walk the sorted row from the bottom, add the kept middle
				for (int j = 0; j < int'(WINDOW) - 1; j++) begin
					sorted_q[j] <= sorted_q[j+1];
				end
				if (idx_q >= IDX_W'(TRIM)) begin
					sum_q <= sum_q + SUM_W'(sorted_q[0]);
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			BK_DIV: begin
				sum_q <= SUM_W'(prod >> DIV_S);
			end
			BK_EMIT: begin
				if (slot_free) begin
					result.channel_out    <= CHAN_IN_W'(chan_q);
					result.filtered_value <= sum_q[SAMPLE_W-1:0];
					result.short_window   <= mask_q[chan_q];
					result.last_result    <= last_chan;
					chan_q <= chan_q + CH_W'(1);
					base_q <= base_q + ADDR_W'(WINDOW);
				end
			end
			default: begin
				rd_idx_q <= '0;
			end
		endcase
	end

	assign result.valid = out_valid_q;

endmodule

/* rtl/core/multichannel_trimmed_mean_filter.sv */
// Top level of the multichannel trimmed mean filter.
//
//  port    dir  payload                                            role
//  adc     in   sample, channel, end_of_block                      tagged converter words
//  result  out  channel_out, filtered_value, short_window, last    one word per channel
//
// A word is taken while valid and ready are high; the store has one write port.
// On a block-end word the back walks every channel: a short one goes from its channel
// step straight to the result slot; a full one runs store reads into the insertion
// row, the trimmed sum walk, one reciprocal multiply to divide, the result slot.
// Two store banks let the next block fill while the back works; input stalls only
// when both banks wait for the back. Output stalls hold the back in its emit step.
// Asynchronous reset clears fill counts, bank ownership and the queue; no clearing pass.
module multichannel_trimmed_mean_filter #(
	parameter int unsigned WINDOW   = mctmf_pkg::WINDOW_DEF,
	parameter int unsigned CHANNELS = mctmf_pkg::CHANNELS_DEF,
	parameter int unsigned TRIM     = mctmf_pkg::TRIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mctmf_in_if.sink    adc,
	mctmf_out_if.source result
);
	import mctmf_pkg::*;

	localparam int unsigned DEPTH  = 2 * CHANNELS * WINDOW;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	cmd_t                q_data;
	cmd_t                q_head;
	done_t               done;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [SAMPLE_W-1:0] wr_data;

	mctmf_front #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adc     (adc),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_data),
		.done    (done),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mctmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	mctmf_back #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS),
		.TRIM     (TRIM)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.done    (done),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.result  (result)
	);

endmodule

/* rtl/core/mctmf_checker.sv */
// Port-level checker for the trimmed mean filter, bound to the top level.
`include "assert_macros.svh"

module mctmf_checker #(
	parameter int unsigned CHANNELS = mctmf_pkg::CHANNELS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [mctmf_pkg::CHAN_IN_W-1:0] channel_out,
	input logic [mctmf_pkg::SAMPLE_W-1:0]  filtered_value,
	input logic                            short_window,
	input logic                            last_result
);
	import mctmf_pkg::*;

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(filtered_value) && $stable(channel_out), "stalled result changed")
	`CHK_SAME(a_last_chan, clk, arst_n, out_valid && last_result, channel_out == CHAN_IN_W'(CHANNELS - 1), "last flag on wrong channel")
	`CHK_SAME(a_short_zero, clk, arst_n, out_valid && short_window, filtered_value == '0, "short channel with nonzero value")

endmodule

bind multichannel_trimmed_mean_filter mctmf_checker #(
	.CHANNELS (CHANNELS)
) u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.channel_out    (result.channel_out),
	.filtered_value (result.filtered_value),
	.short_window   (result.short_window),
	.last_result    (result.last_result)
);

/* verif/testbench.sv */
// Self-checking testbench for the multichannel trimmed mean filter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mctmf_pkg::*;

	localparam int WIN   = WINDOW_DEF;
	localparam int NCH   = CHANNELS_DEF;
	localparam int TRIM  = TRIM_DEF;
	localparam int SETTLE_CYCLES = 800;

	// How the samples of one channel are drawn within a block
	typedef enum int {
		FILL_RANDOM,
		FILL_MAX,
		FILL_RAILS,
		FILL_NARROW
	} fill_style_t;

	// One expected result word
	typedef struct packed {
		logic [CHAN_IN_W-1:0] chan;
		logic [SAMPLE_W-1:0]  value;
		logic                 short_flag;
		logic                 last_flag;
	} mean_word_t;

	logic clk;
	logic arst_n;

	mctmf_in_if  adc_bus ();
	mctmf_out_if result_bus ();

	multichannel_trimmed_mean_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.adc    (adc_bus),
		.result (result_bus)
	);

	// Predictor state: samples held per channel and their count
	logic [SAMPLE_W-1:0] win_samples [NCH][WIN];
	int unsigned         win_fill [NCH];
	mean_word_t          pending_means [$];

	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned hold_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Trimmed average of one full channel of the predictor
	function automatic logic [SAMPLE_W-1:0] trimmed_avg(int ch);
		logic [SAMPLE_W-1:0] row [WIN];
		logic [SAMPLE_W-1:0] v;
		int j;
		int unsigned acc;
		if (2 * TRIM >= WIN)
			return '0;
		for (int i = 0; i < WIN; i++)
			row[i] = win_samples[ch][i];
		// insertion sort, ascending
		for (int i = 1; i < WIN; i++) begin
			v = row[i];
			j = i;
			while (j > 0 && row[j-1] > v) begin
				row[j] = row[j-1];
				j--;
			end
			row[j] = v;
		end
		acc = 0;
		for (int i = TRIM; i < WIN - TRIM; i++)
			acc += row[i];
		return SAMPLE_W'(acc / (WIN - 2 * TRIM));
	endfunction

	// Update the predictor with one accepted word; block end queues one mean per channel
	function automatic void absorb_word(logic [SAMPLE_W-1:0] s, logic [CHAN_IN_W-1:0] c,
			logic e);
		mean_word_t m;
		if (int'(c) < NCH && win_fill[c] < WIN) begin
			win_samples[c][win_fill[c]] = s;
			win_fill[c]++;
		end
		if (e) begin
			for (int ch = 0; ch < NCH; ch++) begin
				m.chan       = CHAN_IN_W'(ch);
				m.short_flag = (win_fill[ch] < WIN);
				m.value      = m.short_flag ? '0 : trimmed_avg(ch);
				m.last_flag  = (ch == NCH - 1);
				pending_means.push_back(m);
			end
			for (int ch = 0; ch < NCH; ch++)
				win_fill[ch] = 0;
		end
	endfunction

	// Offer one word; returns at the edge that accepts it
	task automatic send_word(logic [SAMPLE_W-1:0] s, logic [CHAN_IN_W-1:0] c, logic e);
		bit hit;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			adc_bus.valid <= 1'b0;
			@(posedge clk);
		end
		adc_bus.valid        <= 1'b1;
		adc_bus.sample       <= s;
		adc_bus.channel      <= c;
		adc_bus.end_of_block <= e;
		do begin
			@(negedge clk);
			hit = adc_bus.ready;
			@(posedge clk);
		end while (!hit);
		absorb_word(s, c, e);
		words_sent++;
	endtask

	// Sender goes quiet until every queued mean has come back
	task automatic wait_drained();
		adc_bus.valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] draw_sample(fill_style_t style,
			logic [SAMPLE_W-1:0] base);
		case (style)
			FILL_RANDOM: return SAMPLE_W'($urandom_range(4095));
			FILL_MAX:    return SAMPLE_MAX;
			FILL_RAILS:  return $urandom_range(1) ? SAMPLE_MAX : '0;
			default:     return base + SAMPLE_W'($urandom_range(15));
		endcase
	endfunction

	// One block: a few channels filled to (or past) the window, the rest short,
	// words interleaved at random, block end on the last word
	task automatic run_block();
		int quota [NCH];
		fill_style_t style [NCH];
		logic [SAMPLE_W-1:0] base [NCH];
		int nfull;
		int total;
		int ch;
		nfull = ($urandom_range(5) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
		for (int i = 0; i < NCH; i++) begin
			quota[i] = $urandom_range(2);
			style[i] = fill_style_t'($urandom_range(3));
			base[i]  = SAMPLE_W'($urandom_range(4095));
		end
		for (int i = 0; i < nfull; i++)
			quota[$urandom_range(NCH - 1)] = WIN + $urandom_range(3);
		// now and then a window that falls one short
		if ($urandom_range(5) == 0)
			quota[$urandom_range(NCH - 1)] = WIN - 1;
		total = 0;
		for (int i = 0; i < NCH; i++)
			total += quota[i];
		if (total == 0) begin
			quota[0] = 1;
			total = 1;
		end
		while (total != 0) begin
			do ch = $urandom_range(NCH - 1); while (quota[ch] == 0);
			quota[ch]--;
			total--;
			send_word(draw_sample(style[ch], base[ch]), CHAN_IN_W'(ch), total == 0);
		end
	endtask

	// Extremes of every field, a block that ends on its only word, mixed channels
	task automatic test_directed();
		logic [SAMPLE_W-1:0] pats [NCH];
		pats = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800, 12'h7FF, 12'hFFE};
		gap_pct   = 0;
		stall_pct = 0;
		send_word(12'h000, 3'd0, 1'b1);
		for (int ch = 0; ch < NCH; ch++)
			send_word(pats[ch], CHAN_IN_W'(ch), ch == NCH - 1);
		send_word(12'hFFF, 3'd7, 1'b0);
		send_word(12'h555, 3'd5, 1'b0);
		send_word(12'h000, 3'd3, 1'b1);
		wait_drained();
	endtask

	// Random blocks under each idling mix
	task automatic test_random_blocks();
		int unsigned gaps [4];
		int unsigned stalls [4];
		gaps   = '{0, 63, 0, 28};
		stalls = '{0, 0, 63, 28};
		for (int p = 0; p < 4; p++) begin
			gap_pct   = gaps[p];
			stall_pct = stalls[p];
			run_block();
			wait_drained();
		end
	endtask

	// Receiver holds off long while the sender keeps offering block ends
	task automatic test_output_hold();
		gap_pct   = 0;
		stall_pct = 0;
		hold_req  = 1500;
		for (int b = 0; b < 5; b++) begin
			send_word(SAMPLE_W'($urandom_range(4095)), CHAN_IN_W'($urandom_range(7)), 1'b0);
			send_word(SAMPLE_W'($urandom_range(4095)), CHAN_IN_W'($urandom_range(7)), 1'b1);
		end
		wait_drained();
	endtask

	// Result ready: random stalls, or a long hold-off when one is requested
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Compare every accepted result word with the oldest expected mean
	initial begin
		mean_word_t want;
		forever begin
			@(negedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pending_means.size() == 0) begin
					$error("unexpected result word: channel_out %0d filtered_value %0d",
						result_bus.channel_out, result_bus.filtered_value);
					mismatches++;
				end else begin
					want = pending_means.pop_front();
					if (result_bus.channel_out !== want.chan) begin
						$error("channel_out: expected %0d, got %0d",
							want.chan, result_bus.channel_out);
						mismatches++;
					end
					if (result_bus.filtered_value !== want.value) begin
						$error("filtered_value: expected %0d, got %0d",
							want.value, result_bus.filtered_value);
						mismatches++;
					end
					if (result_bus.short_window !== want.short_flag) begin
						$error("short_window: expected %0b, got %0b",
							want.short_flag, result_bus.short_window);
						mismatches++;
					end
					if (result_bus.last_result !== want.last_flag) begin
						$error("last_result: expected %0b, got %0b",
							want.last_flag, result_bus.last_result);
						mismatches++;
					end
				end
			end
		end
	end

	// Test sequence
	initial begin
		mismatches = 0;
		words_sent = 0;
		gap_pct    = 0;
		stall_pct  = 0;
		hold_req   = 0;
		for (int ch = 0; ch < NCH; ch++)
			win_fill[ch] = 0;
		arst_n               = 1'b0;
		adc_bus.valid        = 1'b0;
		adc_bus.sample       = '0;
		adc_bus.channel      = '0;
		adc_bus.end_of_block = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_blocks();
		test_output_hold();

		// let any stray result words show up
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_means.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
